/* hw/rtl/hrht_pkg.sv */
// ----------------------------------------------------------------------------
// hrht_pkg
// types, codes and byte constants shared by the response head tokenizer
// ----------------------------------------------------------------------------
package hrht_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_STATUS  = 3'd1,
    PH_MESSAGE = 3'd2,
    PH_KEY     = 3'd3,
    PH_SKIP    = 3'd4,
    PH_VALUE   = 3'd5,
    PH_BODY    = 3'd6
  } phase_e;

  // role tag put on each word
  typedef enum logic [2:0] {
    ROLE_VERSION = 3'd0,
    ROLE_STATUS  = 3'd1,
    ROLE_MESSAGE = 3'd2,
    ROLE_KEY     = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_DELIM   = 3'd5,
    ROLE_BODY    = 3'd6
  } role_e;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned CodeW       = 10;
  localparam logic [1:0]  MaxDigits   = 2'd3;

  typedef struct packed {
    phase_e             phase;
    logic               expect_lf;
    logic               line_empty;
    logic [CodeW-1:0]   status_accum;
    logic [1:0]         digit_cnt;
    logic               status_bad;
  } parse_state_t;

  localparam parse_state_t StateRst = '{
    phase:        PH_VERSION,
    expect_lf:    1'b0,
    line_empty:   1'b0,
    status_accum: '0,
    digit_cnt:    2'd0,
    status_bad:   1'b0
  };

  typedef struct packed {
    logic [7:0]         byte_out;
    role_e              role;
    logic               field_end;
    logic [CodeW-1:0]   status_code;
    logic               status_valid;
    logic               head_done;
  } tok_result_t;

endpackage

/* hw/rtl/http_response_head_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// http_response_head_tokenizer_core
// tags each byte of an http response with its role and decodes the status
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | data_byte_i, last_byte_i
//  out     | source    | out_valid_o/out_stall_i| byte_out_o, role_o,
//          |           |                     | field_end_o, status_code_o,
//          |           |                     | status_valid_o, head_done_o
//
//  one word per cycle sustained while out is not stalled; an accepted word passes
//  the input register, then the result register, before it is offered on out
//  the parse state updates as a word moves from the input to the result register
//  reset clears the parse state and both valid flags; no clearing pass
//  a stall on out holds the result; the input register still takes one word,
//  after which in_stall_o follows out_stall_i
//
module http_response_head_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  // tagged words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [2:0] role_o,
  output logic       field_end_o,
  output logic [9:0] status_code_o,
  output logic       status_valid_o,
  output logic       head_done_o
);
  import hrht_pkg::*;

  // input register
  logic         in_valid_q;
  logic [7:0]   data_q;
  logic         last_q;

  // parse state
  parse_state_t state_q, state_d;
  parse_state_t step_state;

  // result register
  logic         out_valid_q;
  tok_result_t  res_q;
  tok_result_t  step_res;

  logic out_free;
  logic in_accept;
  logic fire;

  // result slot is free when empty or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // the held word moves to the result register
  assign fire       = in_valid_q && out_free;
  // input register can take a word when empty or moving on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  hrht_step u_step (
    .state_i  (state_q),
    .data_i   (data_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // last word of a response sends the parser back to the version phase
  always_comb begin
    state_d = state_q;
    if (fire) begin
      state_d = last_q ? StateRst : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateRst;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (fire) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = res_q.byte_out;
  assign role_o         = res_q.role;
  assign field_end_o    = res_q.field_end;
  assign status_code_o  = res_q.status_code;
  assign status_valid_o = res_q.status_valid;
  assign head_done_o    = res_q.head_done;

  // a field end or the end of the head is always tagged as a delimiter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_end_o || head_done_o) |-> role_o == ROLE_DELIM)
    else $error("field_end or head_done on a non-delimiter word");

  // a word never ends a field and the head together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(field_end_o && head_done_o))
    else $error("field_end and head_done together");

  // after the last word of a response the parser is back at its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_q |=> state_q == StateRst)
    else $error("parser not reset after last word");

  // the status code stays within three decimal digits, at most 999
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_code_o <= 10'd999)
    else $error("status code out of range");

endmodule

/* hw/rtl/hrht_step.sv */
// ----------------------------------------------------------------------------
// hrht_step
// per-byte next state and role tag of the response head tokenizer
// ----------------------------------------------------------------------------
module hrht_step (
  input  hrht_pkg::parse_state_t state_i,
  input  logic [7:0]             data_i,
  output hrht_pkg::parse_state_t state_o,
  output hrht_pkg::tok_result_t  result_o
);
  import hrht_pkg::*;

  parse_state_t nxt;
  role_e        role;
  logic         fend;
  logic         hdone;
  logic         is_digit;
  logic [3:0]   digit;

  assign is_digit = (data_i >= CH_ZERO) && (data_i <= CH_NINE);
  assign digit    = data_i[3:0];

  always_comb begin
    nxt   = state_i;
    role  = ROLE_BODY;
    fend  = 1'b0;
    hdone = 1'b0;
    if (state_i.phase == PH_BODY || state_i.phase == phase_e'(3'd7)) begin
      role = ROLE_BODY;
    end else if (state_i.expect_lf) begin
      // second byte of a line end, taken as lf whatever it is
      role          = ROLE_DELIM;
      nxt.expect_lf = 1'b0;
      if (state_i.line_empty) begin
        hdone          = 1'b1;
        nxt.line_empty = 1'b0;
        nxt.phase      = PH_BODY;
      end else begin
        nxt.line_empty = 1'b1;
        nxt.phase      = PH_KEY;
      end
    end else if (data_i == CH_CR) begin
      role          = ROLE_DELIM;
      nxt.expect_lf = 1'b1;
      fend          = !state_i.line_empty;
    end else begin
      nxt.line_empty = 1'b0;
      unique case (state_i.phase)
        PH_VERSION: begin
          if (data_i == CH_SP) begin
            role      = ROLE_DELIM;
            fend      = 1'b1;
            nxt.phase = PH_STATUS;
          end else begin
            role = ROLE_VERSION;
          end
        end
        PH_STATUS: begin
          if (data_i == CH_SP) begin
            role      = ROLE_DELIM;
            fend      = 1'b1;
            nxt.phase = PH_MESSAGE;
          end else begin
            role = ROLE_STATUS;
            if (is_digit && state_i.digit_cnt < MaxDigits) begin
              // accum * 10 as two shifts, at most 999 after three digits
              nxt.status_accum = (state_i.status_accum << 3) + (state_i.status_accum << 1)
                                 + CodeW'(digit);
              nxt.digit_cnt    = state_i.digit_cnt + 2'd1;
            end else begin
              nxt.status_bad = 1'b1;
            end
          end
        end
        PH_MESSAGE: role = ROLE_MESSAGE;
        PH_KEY: begin
          if (data_i == CH_COLON) begin
            role      = ROLE_DELIM;
            fend      = 1'b1;
            nxt.phase = PH_SKIP;
          end else begin
            role = ROLE_KEY;
          end
        end
        PH_SKIP: begin
          role      = ROLE_DELIM;
          nxt.phase = PH_VALUE;
        end
        default: role = ROLE_VALUE;
      endcase
    end
  end

  assign state_o               = nxt;
  assign result_o.byte_out     = data_i;
  assign result_o.role         = role;
  assign result_o.field_end    = fend;
  assign result_o.status_code  = nxt.status_accum;
  assign result_o.status_valid = !nxt.status_bad;
  assign result_o.head_done    = hdone;

endmodule
